// ----- sv/gbdl_pkg.sv -----
`default_nettype none

package gbdl_pkg;

    // Default number of lines on each of the column and row ports.
    localparam int LINES_PER_PORT = 8;

    // Fixed widths of the payload fields.
    localparam int LEVEL_W  = 8;
    localparam int CNT_W    = 8;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 3;
    localparam int MAP_W    = 16;

    // Configuration register file.
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam logic [0:0] REG_DEBOUNCE_TICKS = 1'b0;
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd20;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_NONE   = 2'd0;
    localparam t_status ST_SINGLE = 2'd1;
    localparam t_status ST_MULTI  = 2'd2;

    // What one line lane reports for the item being accepted.
    typedef struct packed {
        logic pressed;  // debounced bit before this item
        logic toggle;   // the bit flips on this item
    } t_lane_out;

    // What the merge stage finds for one item.
    typedef struct packed {
        logic                 changed;
        t_status              status;
        logic [INDEX_W-1:0]   row;
        logic [INDEX_W-1:0]   col;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/gbdl_lane.sv -----
`default_nettype none

module gbdl_lane (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic                      i_raw,
    input  wire logic [gbdl_pkg::CNT_W-1:0] i_ticks,
    output gbdl_pkg::t_lane_out            o_lane
);
    import gbdl_pkg::*;

    logic             r_pressed;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             disagree;
    logic [CNT_W-1:0] cnt_step;
    logic             toggle;

    // Active low: a high raw level disagrees with a pressed bit.
    assign disagree = (i_raw == r_pressed);
    assign cnt_step = disagree ? r_cnt + CNT_W'(1) : '0;
    assign toggle   = (cnt_step == i_ticks);

    always_comb begin
        n_cnt = toggle ? '0 : cnt_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= 1'b0;
            r_cnt     <= '0;
        end else if (i_accept) begin
            r_pressed <= r_pressed ^ toggle;
            r_cnt     <= n_cnt;
        end
    end

    assign o_lane.pressed = r_pressed;
    assign o_lane.toggle  = toggle;

endmodule

`default_nettype wire

// ----- sv/gbdl_merge.sv -----
`default_nettype none

module gbdl_merge #(
    parameter int LPP = gbdl_pkg::LINES_PER_PORT
) (
    input  wire logic [2*LPP-1:0] i_old_bits,
    input  wire logic [2*LPP-1:0] i_toggles,
    output wire logic [2*LPP-1:0] o_new_bits,
    output gbdl_pkg::t_result     o_result
);
    import gbdl_pkg::*;

    localparam int NL = 2 * LPP;

    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] row;
        logic [INDEX_W-1:0] col;
    } t_locate;

    function automatic logic is_one_hot(input logic [LPP-1:0] v);
        is_one_hot = (v != '0) && ((v & (v - LPP'(1))) == '0);
    endfunction

    function automatic logic [INDEX_W-1:0] hot_index(input logic [LPP-1:0] v);
        logic [INDEX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < LPP; i++) begin
            if (v[i]) begin
                idx = idx | INDEX_W'(i);
            end
        end
        hot_index = idx;
    endfunction

    function automatic t_locate recode(input logic [NL-1:0] v);
        t_locate loc;
        logic [LPP-1:0] cols;
        logic [LPP-1:0] rows;
        cols = v[LPP-1:0];
        rows = v[NL-1:LPP];
        loc  = '{status: ST_NONE, row: '0, col: '0};
        if (v == '0) begin
            loc.status = ST_NONE;
        end else if (is_one_hot(cols) && is_one_hot(rows)) begin
            loc.status = ST_SINGLE;
            loc.row    = hot_index(rows);
            loc.col    = hot_index(cols);
        end else begin
            loc.status = ST_MULTI;
        end
        recode = loc;
    endfunction

    t_locate          held;
    t_locate          final_loc;
    logic [NL-1:0]    diff;

    // The held position always equals the recode of the debounced bits.
    assign held       = recode(i_old_bits);
    assign o_new_bits = i_old_bits ^ i_toggles;
    assign final_loc  = recode(o_new_bits);

    // One lane per line: the state right after that line's toggle is the
    // old bits with every toggle up to and including this line applied.
    for (genvar k = 0; k < NL; k++) begin : g_prefix
        logic [NL-1:0] upto;
        t_locate       loc;
        assign upto    = {NL{1'b1}} >> (NL - 1 - k);
        assign loc     = recode(i_old_bits ^ (i_toggles & upto));
        assign diff[k] = i_toggles[k] && (loc != held);
    end

    assign o_result.changed = |diff;
    assign o_result.status  = final_loc.status;
    assign o_result.row     = final_loc.row;
    assign o_result.col     = final_loc.col;

endmodule

`default_nettype wire

// ----- sv/grid_button_debounce_locator_top.sv -----
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_col_levels, i_row_levels
// output    out        o_out_valid / i_out_stall o_changed, o_press_status,
//                                                o_row_index, o_col_index,
//                                                o_pressed_map
// config    in/out     APB psel/penable/pwrite   paddr, pwdata, prdata
//
// One item is accepted per clock while the input is not stalled. An
// accepted item is loaded into the stage one register and then into the
// output register, which presents the result until it is taken.
// Reset is synchronous and active low; it clears all counters, the debounced
// bits and the pipeline valids, and sets the debounce setting to 20.
// A stall on the output holds the output register; the merge stage keeps
// filling until it is also full, and only then is the input stalled.
`default_nettype none

module grid_button_debounce_locator_top #(
    parameter int LINES_PER_PORT = gbdl_pkg::LINES_PER_PORT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            i_in_valid,
    output wire logic                            o_in_stall,
    input  wire logic [gbdl_pkg::LEVEL_W-1:0]    i_col_levels,
    input  wire logic [gbdl_pkg::LEVEL_W-1:0]    i_row_levels,

    output wire logic                            o_out_valid,
    input  wire logic                            i_out_stall,
    output wire logic                            o_changed,
    output wire logic [gbdl_pkg::STATUS_W-1:0]   o_press_status,
    output wire logic [gbdl_pkg::INDEX_W-1:0]    o_row_index,
    output wire logic [gbdl_pkg::INDEX_W-1:0]    o_col_index,
    output wire logic [gbdl_pkg::MAP_W-1:0]      o_pressed_map,

    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [gbdl_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [gbdl_pkg::DATA_W-1:0]     pwdata,
    output wire logic [gbdl_pkg::DATA_W-1:0]     prdata,
    output wire logic                            pready
);
    import gbdl_pkg::*;

    localparam int LPP = LINES_PER_PORT;
    localparam int NL  = 2 * LPP;

    // Configuration register. The word index is the address bit above the
    // byte offset; anything other than word zero is ignored on write and
    // reads back as zero.
    logic [CNT_W-1:0] r_debounce;
    logic             cfg_write;
    logic             cfg_hit;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == REG_DEBOUNCE_TICKS);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = cfg_hit ? DATA_W'(r_debounce) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (cfg_write && cfg_hit) begin
            r_debounce <= pwdata[CNT_W-1:0];
        end
    end

    // Pipeline flow control. The output register frees up when it is empty
    // or its item is taken; the merge stage register frees up when it is
    // empty or can move into the output register.
    logic r_s1_valid;
    logic r_out_valid;
    logic out_free;
    logic s1_free;
    logic in_accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_in_stall = !s1_free;
    assign in_accept  = i_in_valid && s1_free;

    // Raw levels gathered per line: columns in the low lanes, rows above.
    // Lines beyond the eight bits of a level field read as released.
    logic [NL-1:0] levels;

    for (genvar i = 0; i < LPP; i++) begin : g_levels
        if (i < LEVEL_W) begin : g_wired
            assign levels[i]       = i_col_levels[i];
            assign levels[LPP + i] = i_row_levels[i];
        end else begin : g_absent
            assign levels[i]       = 1'b1;
            assign levels[LPP + i] = 1'b1;
        end
    end

    // One debounce lane per line; each keeps its own counter and bit.
    t_lane_out     lanes [NL];
    logic [NL-1:0] old_bits;
    logic [NL-1:0] toggles;

    for (genvar i = 0; i < NL; i++) begin : g_lane
        gbdl_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (in_accept),
            .i_raw    (levels[i]),
            .i_ticks  (r_debounce),
            .o_lane   (lanes[i])
        );
        assign old_bits[i] = lanes[i].pressed;
        assign toggles[i]  = lanes[i].toggle;
    end

    // Stage one: the bits before the item and the lines that toggled.
    logic [NL-1:0] r_s1_bits;
    logic [NL-1:0] r_s1_toggles;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_bits    <= old_bits;
            r_s1_toggles <= toggles;
        end
    end

    // Stage two: the merge replays the toggles in line order.
    logic [NL-1:0] new_bits;
    t_result       result;

    gbdl_merge #(
        .LPP (LPP)
    ) u_merge (
        .i_old_bits (r_s1_bits),
        .i_toggles  (r_s1_toggles),
        .o_new_bits (new_bits),
        .o_result   (result)
    );

    logic [MAP_W-1:0] map_next;

    if (NL >= MAP_W) begin : g_map_cut
        assign map_next = new_bits[MAP_W-1:0];
    end else begin : g_map_pad
        assign map_next = {{(MAP_W-NL){1'b0}}, new_bits};
    end

    t_result          r_result;
    logic [MAP_W-1:0] r_map;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_result <= result;
            r_map    <= map_next;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_changed      = r_result.changed;
    assign o_press_status = r_result.status;
    assign o_row_index    = r_result.row;
    assign o_col_index    = r_result.col;
    assign o_pressed_map  = r_map;

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_press_status != ST_SINGLE))
            |-> (o_row_index == '0) && (o_col_index == '0))
        else $error("position reported without a single press");

    a_none_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_press_status == ST_NONE)) |-> (o_pressed_map == '0))
        else $error("no press reported with pressed bits set");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_s1_valid) |-> o_in_stall)
        else $error("input taken while pipeline is full");
`endif

endmodule

`default_nettype wire
